// ----- rtl/spi_bd_pkg.sv -----
// ---------------------------------------------------------------------------
// spi_bd_pkg
// shared types, constants and helpers of the spi baud divider search
// ---------------------------------------------------------------------------
`default_nettype none

package spi_bd_pkg;

   localparam int unsigned TARGET_W   = 31;
   localparam int unsigned CLOCK_W    = 32;
   localparam int unsigned CODE_W     = 3;
   localparam int unsigned EXP_W      = 4;
   localparam int unsigned BAUD_W     = 8;
   localparam int unsigned LANE_COUNT = 8;
   localparam int unsigned SHIFT_W    = 5;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CLOCK_W-1:0] BUS_CLOCK_RESET = 32'd24000000;

   // register index taken from paddr[2]
   localparam logic REG_BUS_CLOCK = 1'b0;

   // reciprocal constants for division by 3, 5 and 7
   localparam logic [CLOCK_W-1:0] RECIP_DIV3 = 32'hAAAA_AAAB;
   localparam logic [CLOCK_W-1:0] RECIP_DIV5 = 32'hCCCC_CCCD;
   localparam logic [CLOCK_W-1:0] RECIP_DIV7 = 32'h2492_4925;

   typedef enum logic [1:0] {
      SRC_BUS  = 2'd0,
      SRC_DIV3 = 2'd1,
      SRC_DIV5 = 2'd2,
      SRC_DIV7 = 2'd3
   } src_type;

   typedef struct packed {
      logic                  found;
      logic [CODE_W-1:0]     code;
      logic [EXP_W-1:0]      exp;
      logic [TARGET_W-1:0]   rate;
   } cand_type;

   // odd factor of prescaler lane+1
   function automatic src_type lane_src(input int lane);
      src_type src;
      case (lane)
         2:       src = SRC_DIV3;
         4:       src = SRC_DIV5;
         5:       src = SRC_DIV3;
         6:       src = SRC_DIV7;
         default: src = SRC_BUS;
      endcase
      return src;
   endfunction

   // power-of-two factor of prescaler lane+1, plus the divisor's own one
   function automatic logic [SHIFT_W-1:0] lane_shift(input int lane);
      logic [SHIFT_W-1:0] sh;
      case (lane)
         1:       sh = 5'd2;
         3:       sh = 5'd3;
         5:       sh = 5'd2;
         7:       sh = 5'd4;
         default: sh = 5'd1;
      endcase
      return sh;
   endfunction

   // higher rate wins, ties keep the lower prescaler in a
   function automatic cand_type pick(input cand_type a, input cand_type b);
      cand_type w;
      if (b.found && (!a.found || (b.rate > a.rate))) begin
         w = b;
      end else begin
         w = a;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/spi_bd_if.sv -----
// ---------------------------------------------------------------------------
// spi_bd_if
// request and response channels of the spi baud divider search
// ---------------------------------------------------------------------------
`default_nettype none

interface spi_bd_req_if;
   import spi_bd_pkg::*;

   logic                valid;
   logic                ready;
   logic [TARGET_W-1:0] target_hz;

   modport source (output valid, output target_hz, input ready);
   modport sink   (input valid, input target_hz, output ready);
endinterface

interface spi_bd_rsp_if;
   import spi_bd_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] prescale_code;
   logic [EXP_W-1:0]  rate_exponent;
   logic [BAUD_W-1:0] baud_byte;

   modport source (output valid, output prescale_code, output rate_exponent,
                   output baud_byte, input ready);
   modport sink   (input valid, input prescale_code, input rate_exponent,
                   input baud_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/spi_baud_divider_search_top.sv -----
// ---------------------------------------------------------------------------
// spi_baud_divider_search_top
// picks the spi prescaler and exponent whose rate is closest at or below a request
// ---------------------------------------------------------------------------
// A request on req_ch carries a wanted bit rate; rsp_ch returns the prescaler
// code, the exponent and the packed baud byte, one response per request, in
// order. Both channels use a valid/ready handshake.
// The bus clock is held in one apb register at byte address 0; write it only
// while no request is in flight.
// A request passes through registered stages: reciprocal multiply, quotient,
// per-prescaler exponent search, 8-to-2 select, final select. Throughput is
// one request per cycle while the receiver is ready; each stage has its own
// valid bit and takes new data whenever it is empty or its successor moves on.
// When the receiver stalls, full stages hold their data and empty stages
// still fill, so up to five requests are taken before req_ch.ready drops.
// Synchronous reset empties the pipeline and loads a 24 MHz bus clock.
// ---------------------------------------------------------------------------
`default_nettype none

module spi_baud_divider_search_top #(
   parameter int PRESCALE_MAX = 8,
   parameter int EXPONENT_MAX = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   spi_bd_req_if.sink                          req_ch,
   spi_bd_rsp_if.source                        rsp_ch,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [spi_bd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire  [spi_bd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [spi_bd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready
);
   import spi_bd_pkg::*;

   logic [CLOCK_W-1:0]    bus_clock_ff;
   logic                  csr_write;

   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                  en1, en2, en3, en4, en5;

   logic [TARGET_W-1:0]   target1_ff, target2_ff;
   logic [2*CLOCK_W-1:0]  prod3_ff, prod5_ff, prod7_ff;
   logic [CLOCK_W-1:0]    q3_ff, q5_ff, q7_ff;
   logic [CLOCK_W-1:0]    q3_in, q5_in, q7_in;
   logic [CLOCK_W-1:0]    t7;
   logic [CLOCK_W-1:0]    sum7;

   cand_type              lane_in [LANE_COUNT];
   cand_type              lane_ff [LANE_COUNT];
   cand_type              pair_in [2];
   cand_type              pair_ff [2];
   cand_type              final_in;
   logic [CODE_W-1:0]     code_ff;
   logic [EXP_W-1:0]      exp_ff;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_clock_ff <= BUS_CLOCK_RESET;
      end else if (csr_write && (paddr[2] == REG_BUS_CLOCK)) begin
         bus_clock_ff <= pwdata;
      end
   end

   always_comb begin
      if (paddr[2] == REG_BUS_CLOCK) begin
         prdata = bus_clock_ff;
      end else begin
         prdata = '0;
      end
   end

   // stage enables
   assign en5 = !v5_ff || rsp_ch.ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ch.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_ch.valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   // stage 1: reciprocal products
   always_ff @(posedge clock) begin
      if (en1) begin
         target1_ff <= req_ch.target_hz;
         prod3_ff   <= {{CLOCK_W{1'b0}}, bus_clock_ff} * {{CLOCK_W{1'b0}}, RECIP_DIV3};
         prod5_ff   <= {{CLOCK_W{1'b0}}, bus_clock_ff} * {{CLOCK_W{1'b0}}, RECIP_DIV5};
         prod7_ff   <= {{CLOCK_W{1'b0}}, bus_clock_ff} * {{CLOCK_W{1'b0}}, RECIP_DIV7};
      end
   end

   // stage 2: quotients by 3, 5 and 7
   assign t7    = prod7_ff[2*CLOCK_W-1:CLOCK_W];
   assign sum7  = ((bus_clock_ff - t7) >> 1) + t7;
   assign q3_in = CLOCK_W'(prod3_ff >> 33);
   assign q5_in = CLOCK_W'(prod5_ff >> 34);
   assign q7_in = sum7 >> 2;

   always_ff @(posedge clock) begin
      if (en2) begin
         target2_ff <= target1_ff;
         q3_ff      <= q3_in;
         q5_ff      <= q5_in;
         q7_ff      <= q7_in;
      end
   end

   // stage 3: lowest qualifying exponent for each prescaler
   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
      if (i < PRESCALE_MAX) begin : g_used
         always_comb begin
            logic [CLOCK_W-1:0] base;
            logic [SHIFT_W-1:0] sh;
            logic [CLOCK_W-1:0] r;
            case (lane_src(i))
               SRC_DIV3: base = q3_ff;
               SRC_DIV5: base = q5_ff;
               SRC_DIV7: base = q7_ff;
               default:  base = bus_clock_ff;
            endcase
            sh = lane_shift(i);
            lane_in[i].found = 1'b0;
            lane_in[i].code  = CODE_W'(i);
            lane_in[i].exp   = '0;
            lane_in[i].rate  = '0;
            for (int e = EXPONENT_MAX; e >= 0; e--) begin
               r = base >> (sh + SHIFT_W'(e));
               if (r <= {1'b0, target2_ff}) begin
                  lane_in[i].found = 1'b1;
                  lane_in[i].exp   = EXP_W'(e);
                  lane_in[i].rate  = r[TARGET_W-1:0];
               end
            end
         end
      end else begin : g_unused
         assign lane_in[i] = '{found: 1'b0, code: CODE_W'(i), exp: '0, rate: '0};
      end

      always_ff @(posedge clock) begin
         if (en3) begin
            lane_ff[i] <= lane_in[i];
         end
      end
   end

   // stage 4: eight lanes down to two
   assign pair_in[0] = pick(pick(lane_ff[0], lane_ff[1]), pick(lane_ff[2], lane_ff[3]));
   assign pair_in[1] = pick(pick(lane_ff[4], lane_ff[5]), pick(lane_ff[6], lane_ff[7]));

   always_ff @(posedge clock) begin
      if (en4) begin
         pair_ff[0] <= pair_in[0];
         pair_ff[1] <= pair_in[1];
      end
   end

   // stage 5: final choice, zero codes when nothing qualifies
   assign final_in = pick(pair_ff[0], pair_ff[1]);

   always_ff @(posedge clock) begin
      if (en5) begin
         if (final_in.found) begin
            code_ff <= final_in.code;
            exp_ff  <= final_in.exp;
         end else begin
            code_ff <= '0;
            exp_ff  <= '0;
         end
      end
   end

   assign rsp_ch.valid         = v5_ff;
   assign rsp_ch.prescale_code = code_ff;
   assign rsp_ch.rate_exponent = exp_ff;
   assign rsp_ch.baud_byte     = {1'b0, code_ff, exp_ff};

`ifndef SYNTH
   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (int'(rsp_ch.rate_exponent) <= EXPONENT_MAX))
      else $error("exponent beyond range");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (int'(rsp_ch.prescale_code) < PRESCALE_MAX))
      else $error("prescaler code beyond range");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (paddr[2] == REG_BUS_CLOCK)) |=> (bus_clock_ff == $past(pwdata)))
      else $error("bus clock register not written");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !en5) |=> (v4_ff && v5_ff))
      else $error("request lost during stall");

   a_take: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> v1_ff)
      else $error("accepted request not captured");
`endif

endmodule

`default_nettype wire
